/* design/file_signature_sniffer_macros.svh */
// assertion helpers shared by the sniffer modules
`ifndef FILE_SIGNATURE_SNIFFER_MACROS_SVH
`define FILE_SIGNATURE_SNIFFER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fss: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define FSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fss: next-cycle check failed");

`endif

/* design/fss_pkg.sv */
`timescale 1ns / 1ps

package fss_pkg;

  localparam int HEAD_BYTES_DEF   = 64;
  localparam int COUNT_BITS_DEF   = 32;
  localparam int WINDOW_BYTES_DEF = 12;

  localparam logic [31:0] DISC_TAG_POS = 32'h0000_8001;
  localparam int          DISC_TAG_LEN = 5;
  localparam logic [31:0] IMG_TRAILER  = 32'h0303_1998;

  localparam int          BLOB_LEN   = 11;
  localparam int          FWFILE_LEN = 12;
  localparam int          FWF_LEN    = 4;
  localparam logic [87:0] STR_BLOB   = "InPlaceBlob";
  localparam logic [95:0] STR_FWFILE = "FirmwareFile";
  localparam logic [31:0] STR_FWF    = "FWF_";

  // multi-byte magics, first file byte in the low bits
  localparam logic [63:0] SZDD_MAGIC = 64'h3327_F088_4444_5A53;
  localparam logic [63:0] WIM_MAGIC  = 64'h0000_004D_4957_534D;
  localparam logic [31:0] MAG_XBEH   = 32'h4845_4258;
  localparam logic [31:0] MAG_XEX1   = 32'h3158_4558;
  localparam logic [31:0] MAG_XEX2   = 32'h3258_4558;
  localparam logic [31:0] MAG_XUIZ   = 32'h5A49_5558;
  localparam logic [31:0] MAG_LIVE   = 32'h4556_494C;
  localparam logic [31:0] MAG_PIRS   = 32'h5352_4950;
  localparam logic [31:0] MAG_CON    = 32'h204E_4F43;
  localparam logic [15:0] MAG_MZ     = 16'h5A4D;
  localparam logic [15:0] MAG_FWF    = 16'hA103;
  localparam logic [15:0] MAG_PACK   = 16'h96A5;
  localparam logic [15:0] SIG_NE     = 16'h454E;
  localparam logic [15:0] SIG_LE     = 16'h454C;
  localparam logic [15:0] SIG_LX     = 16'h584C;
  localparam logic [31:0] SIG_PE     = 32'h0000_4550;

  typedef enum logic [4:0] {
    FMT_UNKNOWN   = 5'd0,
    FMT_MZ        = 5'd1,
    FMT_PE        = 5'd2,
    FMT_NE        = 5'd3,
    FMT_LE        = 5'd4,
    FMT_LX        = 5'd5,
    FMT_XEX       = 5'd6,
    FMT_XBE       = 5'd7,
    FMT_XUIZ      = 5'd8,
    FMT_LIVE_PIRS = 5'd9,
    FMT_CON       = 5'd10,
    FMT_OS2PACK   = 5'd11,
    FMT_SZDD      = 5'd12,
    FMT_IMG       = 5'd13,
    FMT_FWF       = 5'd14,
    FMT_ISO       = 5'd15,
    FMT_WIM       = 5'd16
  } fmt_t;

  typedef enum logic [1:0] {
    ST_RECOGNIZED = 2'd0,
    ST_SHORT      = 2'd1,
    ST_NONE       = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // everything the decision needs about one file, with its last byte included
  typedef struct packed {
    logic [7:0][7:0] head_lo;
    logic [31:0]     off_field;
    logic [31:0]     trailer;
    logic            string_seen;
    logic            iso;
    logic            n_lt2;
    logic            n_ge4;
    logic            n_ge8;
    logic            n_ge64;
    logic            sig_ne;
    logic            sig_le;
    logic            sig_lx;
    logic            sig_pe;
  } view_t;

  typedef struct packed {
    fmt_t        fmt;
    logic [31:0] offset;
    logic        xex_var;
    status_t     status;
  } verdict_t;

  function automatic logic [7:0] disc_tag_byte(input logic [2:0] idx);
    logic [7:0] chr;
    case (idx)
      3'd0:    chr = 8'h43;
      3'd1:    chr = 8'h44;
      3'd2:    chr = 8'h30;
      3'd3:    chr = 8'h30;
      3'd4:    chr = 8'h31;
      default: chr = 8'h00;
    endcase
    return chr;
  endfunction

endpackage

/* design/fss_in_reg.sv */
`timescale 1ns / 1ps

module fss_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_ready,
  input  fss_pkg::item_t item_in,
  input  logic          advance,
  output logic          stg_valid,
  output fss_pkg::item_t stg_item
);
  import fss_pkg::*;

  assign byte_ready = !stg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      stg_valid <= 1'b1;
    end else if (advance) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      stg_item <= item_in;
    end
  end

endmodule

/* design/fss_track.sv */
`timescale 1ns / 1ps
`include "file_signature_sniffer_macros.svh"

module fss_track #(
  parameter int HEAD_BYTES   = fss_pkg::HEAD_BYTES_DEF,
  parameter int COUNT_BITS   = fss_pkg::COUNT_BITS_DEF,
  parameter int WINDOW_BYTES = fss_pkg::WINDOW_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  fss_pkg::item_t item,
  output fss_pkg::view_t view
);
  import fss_pkg::*;

  localparam int HIDX    = $clog2(HEAD_BYTES);
  localparam int OFF_POS = HEAD_BYTES - 4;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [COUNT_BITS-1:0] count, count_next;
  logic [7:0]            head_lo [8];
  logic [7:0]            head_lo_next [8];
  logic [3:0][7:0]       off_bytes, off_bytes_next;
  logic [7:0]            tail [WINDOW_BYTES];
  logic [7:0]            tail_next [WINDOW_BYTES];
  logic                  string_seen, string_seen_next;
  logic                  disc_match, disc_match_next;
  logic [31:0]           far_sig, far_sig_next;
  logic [HEAD_BYTES-1:0] ne_flags, le_flags, lx_flags, pe_flags;
  logic [HEAD_BYTES-1:0] ne_next, le_next, lx_next, pe_next;

  logic [7:0]            b;
  logic                  counting;
  logic [32:0]           far_diff;
  logic                  far_hit, in_tag;
  logic [2:0]            tag_idx;
  logic                  pair_set, quad_set;
  logic [HIDX-1:0]       pair_idx, quad_idx, off_idx;
  logic                  blob_hit, fwfile_hit, fwf_hit;
  logic                  near, len2_ok, len4_ok;
  logic [32:0]           n_ext;

  always_comb begin
    b        = item.data;
    counting = count != COUNT_MAX;
    count_next = counting ? count + 1'b1 : count;

    for (int i = 0; i < 8; i++) begin
      head_lo_next[i] = (counting && count == COUNT_BITS'(i)) ? b : head_lo[i];
    end
    for (int k = 0; k < 4; k++) begin
      off_bytes_next[k] = (counting && count == COUNT_BITS'(OFF_POS + k)) ? b : off_bytes[k];
    end

    // capture of the four bytes at the header offset, past the head
    far_diff = 33'(count) - {1'b0, off_bytes};
    far_hit  = counting && count >= COUNT_BITS'(HEAD_BYTES) && !far_diff[32] &&
               far_diff[31:2] == '0;
    for (int k = 0; k < 4; k++) begin
      far_sig_next[8*k +: 8] = (far_hit && far_diff[1:0] == 2'(k)) ? b : far_sig[8*k +: 8];
    end

    in_tag  = counting && count >= COUNT_BITS'(DISC_TAG_POS) &&
              count < COUNT_BITS'(DISC_TAG_POS + DISC_TAG_LEN);
    tag_idx = 3'(count - COUNT_BITS'(DISC_TAG_POS));
    disc_match_next = disc_match && !(in_tag && b != disc_tag_byte(tag_idx));

    for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
      tail_next[i] = tail[i + 1];
    end
    tail_next[WINDOW_BYTES-1] = b;

    blob_hit = 1'b1;
    for (int i = 0; i < BLOB_LEN; i++) begin
      if (tail_next[WINDOW_BYTES-BLOB_LEN+i] != STR_BLOB[8*(BLOB_LEN-1-i) +: 8]) begin
        blob_hit = 1'b0;
      end
    end
    fwfile_hit = 1'b1;
    for (int i = 0; i < FWFILE_LEN; i++) begin
      if (tail_next[WINDOW_BYTES-FWFILE_LEN+i] != STR_FWFILE[8*(FWFILE_LEN-1-i) +: 8]) begin
        fwfile_hit = 1'b0;
      end
    end
    fwf_hit = 1'b1;
    for (int i = 0; i < FWF_LEN; i++) begin
      if (tail_next[WINDOW_BYTES-FWF_LEN+i] != STR_FWF[8*(FWF_LEN-1-i) +: 8]) fwf_hit = 1'b0;
    end
    string_seen_next = string_seen || blob_hit || fwfile_hit || fwf_hit;

    // signature flags per start position inside the head, built as bytes pass
    pair_set = counting && count != '0 && count <= COUNT_BITS'(HEAD_BYTES);
    pair_idx = HIDX'(count - COUNT_BITS'(1));
    quad_set = counting && count >= COUNT_BITS'(3) && count <= COUNT_BITS'(HEAD_BYTES + 2);
    quad_idx = HIDX'(count - COUNT_BITS'(3));
    ne_next = ne_flags;
    le_next = le_flags;
    lx_next = lx_flags;
    pe_next = pe_flags;
    if (pair_set) begin
      ne_next[pair_idx] = {b, tail[WINDOW_BYTES-1]} == SIG_NE;
      le_next[pair_idx] = {b, tail[WINDOW_BYTES-1]} == SIG_LE;
      lx_next[pair_idx] = {b, tail[WINDOW_BYTES-1]} == SIG_LX;
    end
    if (quad_set) begin
      pe_next[quad_idx] = {b, tail[WINDOW_BYTES-1], tail[WINDOW_BYTES-2],
                           tail[WINDOW_BYTES-3]} == SIG_PE;
    end

    n_ext   = 33'(count_next);
    near    = off_bytes_next[3:0] < 32'(HEAD_BYTES);
    off_idx = off_bytes_next[0][HIDX-1:0];
    len2_ok = ({1'b0, off_bytes_next} + 33'd2) <= n_ext;
    len4_ok = ({1'b0, off_bytes_next} + 33'd4) <= n_ext;

    for (int i = 0; i < 8; i++) begin
      view.head_lo[i] = head_lo_next[i];
    end
    view.off_field   = off_bytes_next;
    view.trailer     = {tail_next[WINDOW_BYTES-1], tail_next[WINDOW_BYTES-2],
                        tail_next[WINDOW_BYTES-3], tail_next[WINDOW_BYTES-4]};
    view.string_seen = string_seen_next;
    view.iso         = disc_match_next &&
                       count_next >= COUNT_BITS'(DISC_TAG_POS + DISC_TAG_LEN);
    view.n_lt2       = count_next < COUNT_BITS'(2);
    view.n_ge4       = count_next >= COUNT_BITS'(4);
    view.n_ge8       = count_next >= COUNT_BITS'(8);
    view.n_ge64      = count_next >= COUNT_BITS'(HEAD_BYTES);
    view.sig_ne      = near ? ne_next[off_idx] : (len2_ok && far_sig_next[15:0] == SIG_NE);
    view.sig_le      = near ? le_next[off_idx] : (len2_ok && far_sig_next[15:0] == SIG_LE);
    view.sig_lx      = near ? lx_next[off_idx] : (len2_ok && far_sig_next[15:0] == SIG_LX);
    view.sig_pe      = near ? pe_next[off_idx] : (len4_ok && far_sig_next == SIG_PE);
  end

  // per-file state, back to its start values after every last byte
  always_ff @(posedge clk) begin
    if (rst || (go && item.last)) begin
      count       <= '0;
      string_seen <= 1'b0;
      disc_match  <= 1'b1;
      far_sig     <= '0;
      ne_flags    <= '0;
      le_flags    <= '0;
      lx_flags    <= '0;
      pe_flags    <= '0;
      for (int i = 0; i < WINDOW_BYTES; i++) begin
        tail[i] <= '0;
      end
    end else if (go) begin
      count       <= count_next;
      string_seen <= string_seen_next;
      disc_match  <= disc_match_next;
      far_sig     <= far_sig_next;
      ne_flags    <= ne_next;
      le_flags    <= le_next;
      lx_flags    <= lx_next;
      pe_flags    <= pe_next;
      for (int i = 0; i < WINDOW_BYTES; i++) begin
        tail[i] <= tail_next[i];
      end
    end
  end

  // head bytes are only read once written
  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < 8; i++) begin
        head_lo[i] <= head_lo_next[i];
      end
      off_bytes <= off_bytes_next;
    end
  end

  `FSS_ASSERT_NEXT(a_clear_after_last, clk, rst, go && item.last, count == '0 && disc_match)
  `FSS_ASSERT_NEXT(a_count_step, clk, rst, go && !item.last && count != COUNT_MAX,
                   count == $past(count) + 1'b1)

endmodule

/* design/fss_verdict.sv */
`timescale 1ns / 1ps

module fss_verdict (
  input  fss_pkg::view_t    view,
  output fss_pkg::verdict_t verdict
);
  import fss_pkg::*;

  logic [15:0] pack_tail;

  always_comb begin
    pack_tail       = view.head_lo[3:2];
    verdict.fmt     = FMT_UNKNOWN;
    verdict.offset  = '0;
    verdict.xex_var = 1'b0;
    verdict.status  = ST_RECOGNIZED;

    if (view.iso) begin
      verdict.fmt = FMT_ISO;
    end else if (view.n_lt2) begin
      verdict.status = ST_SHORT;
    end else if (view.n_ge64 && view.trailer == IMG_TRAILER) begin
      verdict.fmt = FMT_IMG;
    end else if (view.head_lo[1:0] == MAG_FWF || view.string_seen) begin
      verdict.fmt = FMT_FWF;
    end else if (view.n_ge8 && view.head_lo == SZDD_MAGIC) begin
      verdict.fmt = FMT_SZDD;
    end else if (view.n_ge8 && view.head_lo == WIM_MAGIC) begin
      verdict.fmt = FMT_WIM;
    end else begin
      if (view.n_ge4) begin
        if (view.head_lo[1:0] == MAG_PACK &&
            pack_tail inside {16'h000A, 16'h0A0A, 16'h1400, 16'h0A14, 16'hFFFF, 16'hFFFE}) begin
          verdict.fmt = FMT_OS2PACK;
        end else if (view.head_lo[3:0] == MAG_XBEH) begin
          verdict.fmt = FMT_XBE;
        end else if (view.head_lo[3:0] == MAG_XEX1) begin
          verdict.fmt = FMT_XEX;
        end else if (view.head_lo[3:0] == MAG_XEX2) begin
          verdict.fmt     = FMT_XEX;
          verdict.xex_var = 1'b1;
        end else if (view.head_lo[3:0] == MAG_XUIZ) begin
          verdict.fmt = FMT_XUIZ;
        end else if (view.head_lo[3:0] == MAG_LIVE || view.head_lo[3:0] == MAG_PIRS) begin
          verdict.fmt = FMT_LIVE_PIRS;
        end else if (view.head_lo[3:0] == MAG_CON) begin
          verdict.fmt = FMT_CON;
        end
      end
      if (verdict.fmt == FMT_UNKNOWN) begin
        if (view.head_lo[1:0] != MAG_MZ) begin
          verdict.status = ST_NONE;
        end else begin
          verdict.fmt = FMT_MZ;
          if (view.n_ge64) begin
            verdict.offset = view.off_field;
            if (view.sig_ne) verdict.fmt = FMT_NE;
            else if (view.sig_le) verdict.fmt = FMT_LE;
            else if (view.sig_lx) verdict.fmt = FMT_LX;
            else if (view.sig_pe) verdict.fmt = FMT_PE;
          end
        end
      end
    end
  end

endmodule

/* design/fss_out_reg.sv */
`timescale 1ns / 1ps
`include "file_signature_sniffer_macros.svh"

module fss_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  fss_pkg::verdict_t verdict,
  output logic              out_free,
  output logic              verdict_valid,
  input  logic              verdict_ready,
  output logic [4:0]        format_code,
  output logic [31:0]       header_offset,
  output logic              xex_variant,
  output logic [1:0]        verdict_status
);
  import fss_pkg::*;

  verdict_t result;

  assign out_free       = !verdict_valid || verdict_ready;
  assign format_code    = result.fmt;
  assign header_offset  = result.offset;
  assign xex_variant    = result.xex_var;
  assign verdict_status = result.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (load) begin
      verdict_valid <= 1'b1;
    end else if (verdict_ready) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= verdict;
    end
  end

  `FSS_ASSERT_NEXT(a_load_shows, clk, rst, load, verdict_valid)
  `FSS_ASSERT_IMPL(a_status_fmt, clk, rst, verdict_valid, (result.status == ST_RECOGNIZED) == (result.fmt != FMT_UNKNOWN))
  `FSS_ASSERT_IMPL(a_xex_only, clk, rst, verdict_valid && result.xex_var, result.fmt == FMT_XEX)
  `FSS_ASSERT_IMPL(a_offset_mz, clk, rst, verdict_valid && result.offset != '0, result.fmt == FMT_MZ || result.fmt == FMT_PE || result.fmt == FMT_NE || result.fmt == FMT_LE || result.fmt == FMT_LX)

endmodule

/* design/file_signature_sniffer.sv */
`timescale 1ns / 1ps

// Streaming file-type detector. Feed a file's bytes in order, one transaction
// per byte, with last_byte set on the final one; one verdict transaction
// (format code, header offset, xex variant, status) follows each file, and all
// per-file state is back at its start values for the next file right away.
// Throughput is one byte per clock: each byte goes through an input register,
// then the compares and counter update, with the verdict decoded in that
// same cycle and held in an output register, loaded as its last byte leaves
// the input register. Input stalls only while a last byte waits in
// the input register behind a previous verdict that has not been taken yet.
module file_signature_sniffer #(
  parameter int HEAD_BYTES   = fss_pkg::HEAD_BYTES_DEF,
  parameter int COUNT_BITS   = fss_pkg::COUNT_BITS_DEF,
  parameter int WINDOW_BYTES = fss_pkg::WINDOW_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        verdict_valid,
  input  logic        verdict_ready,
  output logic [4:0]  format_code,
  output logic [31:0] header_offset,
  output logic        xex_variant,
  output logic [1:0]  verdict_status
);
  import fss_pkg::*;

  item_t    item_in, stg_item;
  logic     stg_valid, advance, out_free;
  view_t    view;
  verdict_t verdict;

  assign item_in.data = data_byte;
  assign item_in.last = last_byte;

  // a byte moves on unless it would overwrite an untaken verdict
  assign advance = stg_valid && (!stg_item.last || out_free);

  fss_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .item_in    (item_in),
    .advance    (advance),
    .stg_valid  (stg_valid),
    .stg_item   (stg_item)
  );

  fss_track #(
    .HEAD_BYTES   (HEAD_BYTES),
    .COUNT_BITS   (COUNT_BITS),
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_track (
    .clk  (clk),
    .rst  (rst),
    .go   (advance),
    .item (stg_item),
    .view (view)
  );

  fss_verdict u_verdict (
    .view    (view),
    .verdict (verdict)
  );

  fss_out_reg u_out_reg (
    .clk            (clk),
    .rst            (rst),
    .load           (advance && stg_item.last),
    .verdict        (verdict),
    .out_free       (out_free),
    .verdict_valid  (verdict_valid),
    .verdict_ready  (verdict_ready),
    .format_code    (format_code),
    .header_offset  (header_offset),
    .xex_variant    (xex_variant),
    .verdict_status (verdict_status)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import fss_pkg::*;

  localparam int HEAD_LEN         = HEAD_BYTES_DEF;
  localparam int TAIL_LEN         = WINDOW_BYTES_DEF;
  localparam int RANDOM_BYTES     = 1900;
  localparam int MIN_RANDOM_FILES = 60;
  localparam int IDLE_PCT         = 33;
  localparam int HOLD_CYCLES      = 200;
  localparam int PRESSURE_FILES   = 16;
  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int DRAIN_CYCLES     = 8;
  localparam logic [39:0] CD_TAG  = "CD001";

  typedef struct packed {
    logic       typed;
    logic [3:0] len;
    logic [63:0] lead;   // first file byte in the low bits
    verdict_t   want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        byte_valid;
  logic        byte_ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        verdict_valid;
  logic        verdict_ready;
  logic [4:0]  format_code;
  logic [31:0] header_offset;
  logic        xex_variant;
  logic [1:0]  verdict_status;

  file_signature_sniffer u_top (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_ready     (byte_ready),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .verdict_valid  (verdict_valid),
    .verdict_ready  (verdict_ready),
    .format_code    (format_code),
    .header_offset  (header_offset),
    .xex_variant    (xex_variant),
    .verdict_status (verdict_status)
  );

  always #5 clk = ~clk;

  // predictor state for the file in flight
  logic [31:0] n_seen;
  logic [7:0]  head_mem [HEAD_LEN];
  logic [7:0]  tail_mem [TAIL_LEN];
  logic        name_hit;
  logic        tag_ok;
  logic [31:0] far_word;

  verdict_t    verdicts_due [$];
  logic [7:0]  file_buf [$];
  plan_row_t   plan_rows [8];

  logic        calm = 1'b0;
  logic        hold_req = 1'b0;
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          files_sent = 0;
  int          verdicts_checked = 0;
  int          quiet_cycles = 0;
  int          format_hits [32];

  function automatic logic [31:0] offset_field();
    return {head_mem[63], head_mem[62], head_mem[61], head_mem[60]};
  endfunction

  task automatic forget_file();
    n_seen = '0;
    foreach (head_mem[i]) head_mem[i] = '0;
    foreach (tail_mem[i]) tail_mem[i] = '0;
    name_hit = 1'b0;
    tag_ok   = 1'b1;
    far_word = '0;
  endtask

  task automatic sniff_byte(input logic [7:0] b);
    logic [31:0] p;
    logic [31:0] off;
    logic [8*TAIL_LEN-1:0] tail_vec;
    p = n_seen;
    // the count saturates; later bytes only reach the tail window
    if (p != 32'hFFFF_FFFF) begin
      if (p < HEAD_LEN) head_mem[p] = b;
      if (p >= DISC_TAG_POS && p < DISC_TAG_POS + DISC_TAG_LEN &&
          b != CD_TAG[8*(4 - (p - DISC_TAG_POS)) +: 8])
        tag_ok = 1'b0;
      if (p >= HEAD_LEN) begin
        off = offset_field();
        if (p >= off && p - off < 4) far_word[8*(p - off) +: 8] = b;
      end
      n_seen = p + 1;
    end
    for (int i = 0; i < TAIL_LEN - 1; i++) tail_mem[i] = tail_mem[i + 1];
    tail_mem[TAIL_LEN - 1] = b;
    // newest byte ends up in the low bits, matching string literal packing
    for (int i = 0; i < TAIL_LEN; i++) tail_vec[8*(TAIL_LEN - 1 - i) +: 8] = tail_mem[i];
    if (tail_vec[8*BLOB_LEN-1:0] == STR_BLOB || tail_vec[8*FWFILE_LEN-1:0] == STR_FWFILE ||
        tail_vec[8*FWF_LEN-1:0] == STR_FWF)
      name_hit = 1'b1;
  endtask

  function automatic logic [7:0] byte_at_offset(input logic [31:0] off, input int k);
    longint unsigned pos;
    pos = {32'd0, off} + k;
    if (pos < HEAD_LEN) return head_mem[pos];
    return far_word[8*k +: 8];
  endfunction

  function automatic verdict_t decide_format();
    verdict_t        v;
    logic [31:0]     word0;
    logic [63:0]     lead8;
    logic [31:0]     trailer;
    logic [31:0]     off;
    logic [15:0]     s16;
    logic [31:0]     s32;
    logic            pack_tail;
    longint unsigned n;
    n       = n_seen;
    v       = '0;
    word0   = {head_mem[3], head_mem[2], head_mem[1], head_mem[0]};
    lead8   = {head_mem[7], head_mem[6], head_mem[5], head_mem[4], word0};
    trailer = {tail_mem[TAIL_LEN-1], tail_mem[TAIL_LEN-2], tail_mem[TAIL_LEN-3],
               tail_mem[TAIL_LEN-4]};
    case ({head_mem[3], head_mem[2]})
      16'h000A, 16'h0A0A, 16'h1400, 16'h0A14, 16'hFFFF, 16'hFFFE: pack_tail = 1'b1;
      default: pack_tail = 1'b0;
    endcase
    if (n >= DISC_TAG_POS + DISC_TAG_LEN && tag_ok) v.fmt = FMT_ISO;
    else if (n < 2) v.status = ST_SHORT;
    else if (n >= HEAD_LEN && trailer == IMG_TRAILER) v.fmt = FMT_IMG;
    else if (word0[15:0] == MAG_FWF || name_hit) v.fmt = FMT_FWF;
    else if (n >= 8 && lead8 == SZDD_MAGIC) v.fmt = FMT_SZDD;
    else if (n >= 8 && lead8 == WIM_MAGIC) v.fmt = FMT_WIM;
    else if (n >= 4 && word0[15:0] == MAG_PACK && pack_tail) v.fmt = FMT_OS2PACK;
    else if (n >= 4 && word0 == MAG_XBEH) v.fmt = FMT_XBE;
    else if (n >= 4 && word0 == MAG_XEX1) v.fmt = FMT_XEX;
    else if (n >= 4 && word0 == MAG_XEX2) begin
      v.fmt     = FMT_XEX;
      v.xex_var = 1'b1;
    end
    else if (n >= 4 && word0 == MAG_XUIZ) v.fmt = FMT_XUIZ;
    else if (n >= 4 && (word0 == MAG_LIVE || word0 == MAG_PIRS)) v.fmt = FMT_LIVE_PIRS;
    else if (n >= 4 && word0 == MAG_CON) v.fmt = FMT_CON;
    else if (word0[15:0] != MAG_MZ) v.status = ST_NONE;
    else begin
      v.fmt = FMT_MZ;
      if (n >= HEAD_LEN) begin
        off      = offset_field();
        v.offset = off;
        // no wrap: a huge offset never fits
        if ({32'd0, off} + 64'd2 <= n) begin
          s16 = {byte_at_offset(off, 1), byte_at_offset(off, 0)};
          s32 = {byte_at_offset(off, 3), byte_at_offset(off, 2), s16};
          if (s16 == SIG_NE) v.fmt = FMT_NE;
          else if (s16 == SIG_LE) v.fmt = FMT_LE;
          else if (s16 == SIG_LX) v.fmt = FMT_LX;
          else if ({32'd0, off} + 64'd4 <= n && s32 == SIG_PE) v.fmt = FMT_PE;
        end
      end
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at verdict %0d: %s got 0x%0h want 0x%0h",
             verdicts_checked, what, got, want);
    mismatches++;
  endtask

  // one byte transaction; the predictor runs once the byte is taken
  task automatic push_byte(input logic [7:0] b, input logic is_last, input logic typed,
                           input verdict_t want);
    logic     taken;
    verdict_t got;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= is_last;
    do begin
      @(negedge clk);
      taken = byte_ready;
      @(posedge clk);
    end while (!taken);
    sniff_byte(b);
    bytes_sent++;
    if (is_last) begin
      got = decide_format();
      forget_file();
      verdicts_due.push_back(typed ? want : got);
      files_sent++;
    end
  endtask

  task automatic ship_file();
    for (int i = 0; i < file_buf.size(); i++)
      push_byte(file_buf[i], i == file_buf.size() - 1, 1'b0, '0);
  endtask

  task automatic build_random_file();
    int              kind;
    int              len;
    int              lead_len;
    int              text_len;
    int              at;
    logic [63:0]     lead;
    logic [95:0]     text;
    logic [31:0]     off;
    logic [31:0]     sig;
    longint unsigned pos;
    file_buf.delete();
    kind = $urandom_range(99);
    if (kind < 10) len = $urandom_range(1, 6);
    else if (kind < 30) len = $urandom_range(2, 20);
    else if (kind < 65) len = ($urandom_range(9) == 0) ? $urandom_range(101, 400)
                                                        : $urandom_range(64, 100);
    else if (kind < 75) len = $urandom_range(4, 40);
    else if (kind < 85) len = $urandom_range(58, 90);
    else len = $urandom_range(2, 100);
    repeat (len) file_buf.push_back($urandom_range(255));

    if (kind >= 10 && kind < 30) begin
      // leading magic, sometimes cut short by the file length
      lead_len = 4;
      case ($urandom_range(13))
        0:  begin lead = SZDD_MAGIC; lead_len = 8; end
        1:  begin lead = WIM_MAGIC;  lead_len = 8; end
        2:  lead = {32'd0, MAG_XBEH};
        3:  lead = {32'd0, MAG_XEX1};
        4:  lead = {32'd0, MAG_XEX2};
        5:  lead = {32'd0, MAG_XUIZ};
        6:  lead = {32'd0, MAG_LIVE};
        7:  lead = {32'd0, MAG_PIRS};
        8:  lead = {32'd0, MAG_CON};
        9:  begin
          case ($urandom_range(5))
            0:       lead = {32'd0, 16'h000A, MAG_PACK};
            1:       lead = {32'd0, 16'h0A0A, MAG_PACK};
            2:       lead = {32'd0, 16'h1400, MAG_PACK};
            3:       lead = {32'd0, 16'h0A14, MAG_PACK};
            4:       lead = {32'd0, 16'hFFFF, MAG_PACK};
            default: lead = {32'd0, 16'hFFFE, MAG_PACK};
          endcase
        end
        10: lead = {32'd0, 16'($urandom()), MAG_PACK};
        11: begin lead = {48'd0, MAG_FWF}; lead_len = 2; end
        12: begin lead = {48'd0, MAG_MZ};  lead_len = 2; end
        default: begin
          lead = SZDD_MAGIC ^ (64'd1 << $urandom_range(63));
          lead_len = 8;
        end
      endcase
      for (int k = 0; k < lead_len && k < len; k++) file_buf[k] = lead[8*k +: 8];
    end else if (kind >= 30 && kind < 65) begin
      file_buf[0] = MAG_MZ[7:0];
      file_buf[1] = MAG_MZ[15:8];
      case ($urandom_range(7))
        0:       off = $urandom_range(2, 56);
        1:       off = $urandom_range(61, 63);
        2, 3, 4: off = $urandom_range(64, len - 4);
        5:       off = len - $urandom_range(1, 3);
        6:       off = len + $urandom_range(0, 2);
        default: off = $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(3) : $urandom();
      endcase
      case ($urandom_range(5))
        0:       sig = {16'd0, SIG_NE};
        1:       sig = {16'd0, SIG_LE};
        2:       sig = {16'd0, SIG_LX};
        3, 4:    sig = SIG_PE;
        default: sig = $urandom();
      endcase
      // pe with junk in the upper half must stay plain mz
      if ($urandom_range(9) == 0) sig[31:16] = $urandom_range(1, 16'hFFFF);
      for (int k = 0; k < 4; k++) begin
        pos = {32'd0, off} + k;
        if (pos < len && (pos >= HEAD_LEN || (pos >= 2 && pos < 60)))
          file_buf[pos] = sig[8*k +: 8];
      end
      for (int k = 0; k < 4; k++) file_buf[60 + k] = off[8*k +: 8];
    end else if (kind >= 65 && kind < 75) begin
      case ($urandom_range(4))
        0:       begin text = 96'(STR_BLOB);   text_len = BLOB_LEN;   end
        1:       begin text = 96'(STR_FWFILE); text_len = FWFILE_LEN; end
        2:       begin text = 96'(STR_FWF);    text_len = FWF_LEN;    end
        3:       begin text = 96'(STR_FWFILE[95:8]); text_len = FWFILE_LEN - 1; end
        default: begin text = 96'(STR_FWF[31:8]);    text_len = FWF_LEN - 1;    end
      endcase
      at = (len > text_len) ? $urandom_range(0, len - text_len) : 0;
      for (int j = 0; j < text_len; j++)
        if (at + j < len) file_buf[at + j] = text[8*(text_len - 1 - j) +: 8];
    end else if (kind >= 75 && kind < 85) begin
      sig = IMG_TRAILER;
      if ($urandom_range(3) == 0) sig = sig ^ (32'd1 << $urandom_range(31));
      for (int k = 0; k < 4; k++) file_buf[len - 4 + k] = sig[8*k +: 8];
      if ($urandom_range(1)) begin
        file_buf[0] = MAG_MZ[7:0];
        file_buf[1] = MAG_MZ[15:8];
      end
    end else if (kind >= 85 && $urandom_range(1)) begin
      file_buf[0] = MAG_MZ[7:0];
    end
  endtask

  // files long enough to reach the disc tag
  task automatic build_big_file(input int variant);
    int          len;
    logic [31:0] off;
    logic [31:0] sig;
    file_buf.delete();
    case (variant)
      0:       len = DISC_TAG_POS + DISC_TAG_LEN;
      1:       len = DISC_TAG_POS + DISC_TAG_LEN + $urandom_range(1, 64);
      default: len = DISC_TAG_POS + DISC_TAG_LEN - 1;
    endcase
    repeat (len) file_buf.push_back($urandom_range(255));
    for (int k = 0; k < DISC_TAG_LEN; k++)
      if (DISC_TAG_POS + k < len) file_buf[DISC_TAG_POS + k] = CD_TAG[8*(4 - k) +: 8];
    if (variant != 0) begin
      if (variant == 1)
        file_buf[DISC_TAG_POS + $urandom_range(4)] ^= 8'(1 << $urandom_range(7));
      // new header well past the head but ahead of the disc tag
      off = (variant == 1) ? 32'h7F00 + $urandom_range(64) : 32'h7000 + $urandom_range(64);
      sig = (variant == 1) ? SIG_PE : {16'd0, SIG_NE};
      file_buf[0] = MAG_MZ[7:0];
      file_buf[1] = MAG_MZ[15:8];
      for (int k = 0; k < 4; k++) begin
        file_buf[60 + k]  = off[8*k +: 8];
        file_buf[off + k] = sig[8*k +: 8];
      end
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    verdict_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        @(posedge clk);
        verdict_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        @(posedge clk);
        verdict_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // verdict checker: handshake values are stable at the falling edge
  always @(negedge clk) begin
    verdict_t due;
    if (!rst && verdict_valid && verdict_ready) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("unexpected verdict, format_code", 32'(format_code), '0);
      end else begin
        due = verdicts_due.pop_front();
        if (format_code !== due.fmt)
          report_mismatch("format_code", 32'(format_code), 32'(due.fmt));
        if (header_offset !== due.offset)
          report_mismatch("header_offset", header_offset, due.offset);
        if (xex_variant !== due.xex_var)
          report_mismatch("xex_variant", 32'(xex_variant), 32'(due.xex_var));
        if (verdict_status !== due.status)
          report_mismatch("verdict_status", 32'(verdict_status), 32'(due.status));
      end
      if (format_code < 17) format_hits[format_code]++;
      verdicts_checked++;
    end
  end

  always @(negedge clk) begin
    if (rst || (byte_valid && byte_ready) || (verdict_valid && verdict_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("no transaction for %0d cycles, %0d verdicts outstanding",
                 quiet_cycles, verdicts_due.size());
        $display("file_signature_sniffer verification failed");
        $finish;
      end
    end
  end

  initial begin
    int rand_bytes;
    int rand_files;
    int kinds_seen;
    rst        = 1'b1;
    byte_valid = 1'b0;
    data_byte  = '0;
    last_byte  = 1'b0;
    rand_bytes = 0;
    rand_files = 0;
    kinds_seen = 0;
    foreach (format_hits[i]) format_hits[i] = 0;
    forget_file();

    plan_rows[0] = '{1'b1, 4'd1, 64'h00, '{FMT_UNKNOWN, 32'd0, 1'b0, ST_SHORT}};
    plan_rows[1] = '{1'b1, 4'd2, {48'd0, MAG_MZ}, '{FMT_MZ, 32'd0, 1'b0, ST_RECOGNIZED}};
    plan_rows[2] = '{1'b1, 4'd2, {48'd0, MAG_FWF}, '{FMT_FWF, 32'd0, 1'b0, ST_RECOGNIZED}};
    plan_rows[3] = '{1'b1, 4'd4, {32'd0, MAG_XEX2}, '{FMT_XEX, 32'd0, 1'b1, ST_RECOGNIZED}};
    plan_rows[4] = '{1'b1, 4'd4, {32'd0, 16'hFFFF, MAG_PACK},
                     '{FMT_OS2PACK, 32'd0, 1'b0, ST_RECOGNIZED}};
    plan_rows[5] = '{1'b1, 4'd2, 64'hFFFF, '{FMT_UNKNOWN, 32'd0, 1'b0, ST_NONE}};
    plan_rows[6] = '{1'b1, 4'd4, {32'd0, MAG_CON}, '{FMT_CON, 32'd0, 1'b0, ST_RECOGNIZED}};
    // szdd magic cut to four bytes
    plan_rows[7] = '{1'b0, 4'd4, {32'd0, SZDD_MAGIC[31:0]}, '0};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan_rows[r])
      for (int i = 0; i < plan_rows[r].len; i++)
        push_byte(plan_rows[r].lead[8*i +: 8], i == plan_rows[r].len - 1,
                  plan_rows[r].typed, plan_rows[r].want);

    // long receiver hold-off while short files keep coming, so the input backs up
    hold_req = 1'b1;
    calm     = 1'b1;
    repeat (PRESSURE_FILES) begin
      file_buf.delete();
      repeat ($urandom_range(2, 4)) file_buf.push_back($urandom_range(255));
      ship_file();
    end
    calm = 1'b0;

    while (rand_bytes < RANDOM_BYTES || rand_files < MIN_RANDOM_FILES) begin
      calm = (rand_files >= 40 && rand_files < 70);
      build_random_file();
      ship_file();
      rand_bytes += file_buf.size();
      rand_files++;
    end
    calm = 1'b0;

    for (int v = 0; v < 3; v++) begin
      build_big_file(v);
      ship_file();
    end

    byte_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    foreach (format_hits[i]) if (format_hits[i] != 0) kinds_seen++;
    $display("streamed %0d files (%0d bytes, three past the disc tag offset)",
             files_sent, bytes_sent);
    $display("%0d verdicts checked, %0d distinct format codes observed, %0d mismatches",
             verdicts_checked, kinds_seen, mismatches);
    if (mismatches == 0) $display("file_signature_sniffer verification clean");
    else $display("file_signature_sniffer verification failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/fss_pkg.sv
design/fss_in_reg.sv
design/fss_track.sv
design/fss_verdict.sv
design/fss_out_reg.sv
design/file_signature_sniffer.sv
verif/testbench.sv
